/* hw/rtl/depth_pseudocolor_ramp_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the depth pseudo-color ramp
// Shared property templates used by the RTL assertions of this block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PSEUDOCOLOR_RAMP_DEFINES_SVH
`define DEPTH_PSEUDOCOLOR_RAMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/dpr_pkg.sv */
// ----------------------------------------------------------------------------
// Depth pseudo-color ramp package
// Widths, constants and the record that flows down the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dpr_pkg;

	localparam int GRAY_W  = 8;
	localparam int SPAN_W  = 16;
	localparam int COLOR_W = 8;
	localparam int PROD_W  = GRAY_W + SPAN_W;
	// 510 * v with v < 2^16 needs 25 bits.
	localparam int NUM_W   = SPAN_W + 9;
	localparam int QUO_W   = COLOR_W;
	localparam int NUM_CELLS = QUO_W;
	// x / 255 is taken as (x * (2^24 + 2^16 + 2^8 + 2)) >> 32, exact for x < 2^24.
	localparam int RECIP_W = PROD_W + 25;
	localparam int RECIP_SHIFT = 32;

	localparam logic [COLOR_W-1:0] COLOR_MAX = '1;
	localparam logic [COLOR_W-1:0] COLOR_OFF = '0;

	localparam logic [SPAN_W-1:0] NEAR_RESET = 16'd0;
	localparam logic [SPAN_W-1:0] FAR_RESET  = 16'd255;

	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_FAR  = 1'b1;

	typedef struct packed {
		logic               valid;
		logic               black;  // pixel shows as black
		logic               lower;  // lower half of the ramp: red is full
		logic [SPAN_W-1:0]  span;
		logic [NUM_W-1:0]   rem;
		logic [QUO_W-1:0]   quo;
	} div_t;

endpackage

`default_nettype wire

/* hw/rtl/dpr_scale.sv */
// ----------------------------------------------------------------------------
// Depth pseudo-color ramp front end
// Scales gray onto the span, picks the ramp half and builds the dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_scale (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [dpr_pkg::GRAY_W-1:0] gray,
	input  wire logic [dpr_pkg::SPAN_W-1:0] span,
	input  wire logic                       span_ok,
	output dpr_pkg::div_t                   head
);

	logic                        valid_s1, valid_s2, valid_s3;
	logic [dpr_pkg::PROD_W-1:0]  prod_s1;
	logic [dpr_pkg::SPAN_W-1:0]  span_s1, span_s2, span_s3;
	logic                        ok_s1, ok_s2;
	logic [dpr_pkg::SPAN_W-1:0]  q_s2;
	logic                        black_s3, lower_s3;
	logic [dpr_pkg::NUM_W-1:0]   num_s3;

	logic [dpr_pkg::RECIP_W-1:0] recip_prod;
	logic [dpr_pkg::SPAN_W-1:0]  q_next;
	logic                        lower_next, black_next;
	logic [dpr_pkg::SPAN_W-1:0]  pick;
	logic [dpr_pkg::NUM_W-1:0]   pick_ext, num_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Multiplication by the reciprocal of 255 as four shifted copies.
	assign recip_prod = (dpr_pkg::RECIP_W'(prod_s1) << 24) + (dpr_pkg::RECIP_W'(prod_s1) << 16)
		+ (dpr_pkg::RECIP_W'(prod_s1) << 8) + (dpr_pkg::RECIP_W'(prod_s1) << 1);
	assign q_next = recip_prod[dpr_pkg::RECIP_SHIFT +: dpr_pkg::SPAN_W];

	assign lower_next = {q_s2, 1'b0} < {1'b0, span_s2};
	assign black_next = !ok_s2 || (q_s2 == '0) || (q_s2 >= span_s2);
	assign pick       = lower_next ? q_s2 : span_s2 - q_s2;
	assign pick_ext   = dpr_pkg::NUM_W'(pick);
	// 510 * pick = 512 * pick - 2 * pick.
	assign num_next   = black_next ? '0 : (pick_ext << 9) - (pick_ext << 1);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= dpr_pkg::PROD_W'(gray) * dpr_pkg::PROD_W'(span);
			span_s1  <= span;
			ok_s1    <= span_ok;
			q_s2     <= q_next;
			span_s2  <= span_s1;
			ok_s2    <= ok_s1;
			black_s3 <= black_next;
			lower_s3 <= lower_next;
			num_s3   <= num_next;
			span_s3  <= span_s2;
		end
	end

	assign head.valid = valid_s3;
	assign head.black = black_s3;
	assign head.lower = lower_s3;
	assign head.span  = span_s3;
	assign head.rem   = num_s3;
	assign head.quo   = '0;

endmodule

`default_nettype wire

/* hw/rtl/dpr_cell.sv */
// ----------------------------------------------------------------------------
// Depth pseudo-color ramp divider cell
// One restoring-division step: settles one quotient bit and passes on.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_cell #(
	parameter int SHIFT = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire dpr_pkg::div_t d_in,
	output dpr_pkg::div_t d_out
);

	logic [dpr_pkg::NUM_W-1:0] dvs;
	logic                      ge;
	dpr_pkg::div_t             nxt;
	logic                      valid_q;
	dpr_pkg::div_t             pay_q;

	assign dvs = dpr_pkg::NUM_W'(d_in.span) << SHIFT;
	assign ge  = d_in.rem >= dvs;

	always_comb begin
		nxt     = d_in;
		nxt.rem = ge ? d_in.rem - dvs : d_in.rem;
		nxt.quo = d_in.quo | (dpr_pkg::QUO_W'(ge) << SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		d_out       = pay_q;
		d_out.valid = valid_q;
	end

endmodule

`default_nettype wire

/* hw/rtl/depth_pseudocolor_ramp.sv */
// ----------------------------------------------------------------------------
// Depth pseudo-color ramp
// Maps an 8-bit gray pixel onto a red-to-green ramp over the configured span.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock while the output is not stalled and
// passes it through three scaling stages, a row of eight divider cells that
// each settle one bit of the ramp channel, and the output register. A stall
// on the output side freezes the whole pipeline, and s_tready follows it.
// near_distance and far_distance may be written only while no pixel is in
// flight.
`default_nettype none

`include "depth_pseudocolor_ramp_defines.svh"

module depth_pseudocolor_ramp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [dpr_pkg::SPAN_W-1:0]  cfg_wdata,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // [7:0] gray_level
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [23:0]                      m_tdata   // red_level, green_level, blue_level
);

	logic [dpr_pkg::SPAN_W-1:0] near_q, far_q;
	logic [dpr_pkg::SPAN_W-1:0] span;
	logic                       span_ok;
	logic                       advance;
	dpr_pkg::div_t              chain [0:dpr_pkg::NUM_CELLS];
	logic                       m_tvalid_q;
	logic [23:0]                m_tdata_q;
	logic [dpr_pkg::COLOR_W-1:0] red_next, green_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= dpr_pkg::NEAR_RESET;
			far_q  <= dpr_pkg::FAR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dpr_pkg::REG_NEAR: near_q <= cfg_wdata;
				dpr_pkg::REG_FAR:  far_q  <= cfg_wdata;
				default:           near_q <= near_q;
			endcase
		end
	end

	assign span    = far_q - near_q;
	assign span_ok = far_q > near_q;

	assign advance  = !m_tvalid_q || m_tready;
	assign s_tready = advance;

	dpr_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (s_tvalid),
		.gray     (s_tdata[dpr_pkg::GRAY_W-1:0]),
		.span     (span),
		.span_ok  (span_ok),
		.head     (chain[0])
	);

	for (genvar i = 0; i < dpr_pkg::NUM_CELLS; i++) begin : g_cell
		dpr_cell #(
			.SHIFT (dpr_pkg::NUM_CELLS - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.d_in   (chain[i]),
			.d_out  (chain[i+1])
		);
	end

	always_comb begin
		priority if (chain[dpr_pkg::NUM_CELLS].black) begin
			red_next   = dpr_pkg::COLOR_OFF;
			green_next = dpr_pkg::COLOR_OFF;
		end else if (chain[dpr_pkg::NUM_CELLS].lower) begin
			red_next   = dpr_pkg::COLOR_MAX;
			green_next = chain[dpr_pkg::NUM_CELLS].quo;
		end else begin
			red_next   = chain[dpr_pkg::NUM_CELLS].quo;
			green_next = dpr_pkg::COLOR_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= chain[dpr_pkg::NUM_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {dpr_pkg::COLOR_OFF, green_next, red_next};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Outside black, one of the two channels is always at full scale.
	`DPR_ASSERT_IMP(a_ramp_full_channel, clk, arst_n, m_tvalid_q, (m_tdata_q[7:0] == dpr_pkg::COLOR_MAX) || (m_tdata_q[15:8] == dpr_pkg::COLOR_MAX) || (m_tdata_q[15:0] == 16'h0000), "neither channel full on a colored pixel")
	// An empty or reversed span must reach the end of the chain as black.
	`DPR_ASSERT_IMP(a_bad_span_black, clk, arst_n, chain[dpr_pkg::NUM_CELLS].valid && !span_ok, chain[dpr_pkg::NUM_CELLS].black, "pixel with empty span not black")
	// A stall freezes the tail of the divider chain.
	`DPR_ASSERT_NXT(a_tail_frozen, clk, arst_n, !advance, $stable(chain[dpr_pkg::NUM_CELLS].valid) && $stable(chain[dpr_pkg::NUM_CELLS].quo), "divider tail moved during stall")

endmodule

`default_nettype wire

/* bench/depth_pseudocolor_ramp_tb.sv */
// ----------------------------------------------------------------------------
// Depth pseudo-color ramp testbench
// Streams gray pixels through the ramp under several span settings and
// handshake pressure, and checks every color against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pseudocolor_ramp_tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [dpr_pkg::COLOR_W-1:0] blue;
		logic [dpr_pkg::COLOR_W-1:0] green;
		logic [dpr_pkg::COLOR_W-1:0] red;
	} color_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = dpr_pkg::REG_NEAR;
	logic [dpr_pkg::SPAN_W-1:0]  cfg_wdata = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata = '0;  // [7:0] gray_level
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [23:0]                 m_tdata;       // [7:0] red, [15:8] green, [23:16] blue

	logic [dpr_pkg::SPAN_W-1:0]  span_near = dpr_pkg::NEAR_RESET;
	logic [dpr_pkg::SPAN_W-1:0]  span_far = dpr_pkg::FAR_RESET;
	int unsigned                 sender_idle_pct = 0;
	int unsigned                 receiver_stall_pct = 0;
	int unsigned                 mismatch_count = 0;
	color_t                      pending_colors[$];

	depth_pseudocolor_ramp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Color of one gray pixel under the current span registers.
	function automatic color_t ramp_color(input logic [dpr_pkg::GRAY_W-1:0] gray);
		int unsigned span;
		int unsigned scaled;
		color_t      c;
		c = '0;
		if (span_far > span_near) begin
			span = span_far - span_near;
			scaled = (gray * span) / 255;
			// Pixels at either end of the span are shown black.
			if (scaled != 0 && scaled < span) begin
				if (2 * scaled < span) begin
					c.red = dpr_pkg::COLOR_MAX;
					c.green = dpr_pkg::COLOR_W'((510 * scaled) / span);
				end else begin
					c.red = dpr_pkg::COLOR_W'((510 * (span - scaled)) / span);
					c.green = dpr_pkg::COLOR_MAX;
				end
			end
		end
		return c;
	endfunction

	always @(posedge clk) begin
		m_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		color_t got;
		color_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_colors.size() == 0) begin
				$error("unexpected color transaction %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_colors.pop_front();
				if (got.red !== want.red) begin
					$error("red_level: expected %0d, got %0d", want.red, got.red);
					mismatch_count++;
				end
				if (got.green !== want.green) begin
					$error("green_level: expected %0d, got %0d", want.green, got.green);
					mismatch_count++;
				end
				if (got.blue !== want.blue) begin
					$error("blue_level: expected %0d, got %0d", want.blue, got.blue);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_pixel(input logic [dpr_pkg::GRAY_W-1:0] gray);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= gray;
		do @(posedge clk); while (!s_tready);
		pending_colors.insert(pending_colors.size(), ramp_color(gray));
	endtask

	// Always waits on the clock before it returns, so back-to-back register writes
	// never collide on the write enable.
	task automatic drain_pixels();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_colors.size() != 0);
	endtask

	task automatic set_span(input logic [dpr_pkg::SPAN_W-1:0] near_val,
			input logic [dpr_pkg::SPAN_W-1:0] far_val);
		drain_pixels();
		cfg_we <= 1'b1;
		cfg_index <= dpr_pkg::REG_NEAR;
		cfg_wdata <= near_val;
		@(posedge clk);
		cfg_index <= dpr_pkg::REG_FAR;
		cfg_wdata <= far_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		span_near = near_val;
		span_far = far_val;
	endtask

	task automatic test_reset_span();
		logic [dpr_pkg::GRAY_W-1:0] grays[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd85,
			8'd170, 8'd255};
		foreach (grays[i]) send_pixel(grays[i]);
	endtask

	task automatic test_span_extremes();
		// Widest span: both halves of the ramp and the black far end.
		set_span(16'd0, 16'hFFFF);
		send_pixel(8'd1);
		send_pixel(8'd127);
		send_pixel(8'd128);
		send_pixel(8'd254);
		send_pixel(8'd255);
		// Reversed span is black everywhere.
		set_span(16'hFFFF, 16'd0);
		send_pixel(8'd128);
		send_pixel(8'd255);
		// Empty span.
		set_span(16'hFFFF, 16'hFFFF);
		send_pixel(8'd200);
		// A span of two: only grays from 128 to 254 land inside it.
		set_span(16'd10, 16'd12);
		send_pixel(8'd127);
		send_pixel(8'd128);
		send_pixel(8'd255);
		// A span of one has no inside at all.
		set_span(16'd300, 16'd301);
		send_pixel(8'd254);
		send_pixel(8'd255);
	endtask

	task automatic test_random_spans();
		int unsigned idle_modes[4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{29, 29}};
		logic [dpr_pkg::SPAN_W-1:0] near_val;
		logic [dpr_pkg::SPAN_W-1:0] far_val;
		int unsigned                pick;
		foreach (idle_modes[m]) begin
			for (int seg = 0; seg < 3; seg++) begin
				unique case (seg)
					0: begin
						near_val = dpr_pkg::SPAN_W'($urandom_range(2000));
						far_val = near_val + dpr_pkg::SPAN_W'($urandom_range(700, 1));
					end
					1: begin
						near_val = dpr_pkg::SPAN_W'($urandom);
						far_val = dpr_pkg::SPAN_W'($urandom);
					end
					default: begin
						near_val = dpr_pkg::SPAN_W'($urandom_range(255));
						far_val = 16'hFFFF - dpr_pkg::SPAN_W'($urandom_range(255));
					end
				endcase
				set_span(near_val, far_val);
				sender_idle_pct = idle_modes[m][0];
				receiver_stall_pct = idle_modes[m][1];
				repeat (162) begin
					pick = $urandom_range(15);
					if (pick == 0)
						send_pixel(8'd0);
					else if (pick == 1)
						send_pixel(8'd255);
					else
						send_pixel(8'($urandom));
				end
				drain_pixels();
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_span();
		test_span_extremes();
		test_random_spans();
		drain_pixels();
		repeat (24) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
